// ----- sv/floyd_sample_without_replacement_defines.svh -----
// Assertion macros shared by the Floyd sampler RTL.
// Every macro samples on clk and is disabled while rst is high.
`ifndef FLOYD_SAMPLE_WITHOUT_REPLACEMENT_DEFINES_SVH
`define FLOYD_SAMPLE_WITHOUT_REPLACEMENT_DEFINES_SVH

// General property check.
`define FSW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same-cycle implication from a condition to a consequence.
`define FSW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- sv/fsw_pkg.sv -----
// Shared constants, types and helper functions for the Floyd sampler.
// No dependencies; used by fsw_bitmap, fsw_ctrl and the top level.
`timescale 1ns / 1ps
`default_nettype none

package fsw_pkg;

  // Width of the configuration registers and of the internal counters.
  localparam int CNT_W = 13;
  // Width of the emitted index and ordinal.
  localparam int OUT_W = 12;
  // Bitmap row width and the bit-select width within a row.
  localparam int ROW_W = 32;
  localparam int BIT_W = 5;
  // Default population capacity.
  localparam int POP_MAX_DEF = 4096;

  // Item kinds carried in tuser.
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_WORD  = 1'b1;

  // Configuration register indexes.
  localparam logic REG_POP_SIZE    = 1'b0;
  localparam logic REG_SAMPLE_SIZE = 1'b1;

  // Bitmap port control.
  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

  // Smears the leading one downward: gives 2*p-1 where p is the largest
  // power of two not above x.
  function automatic logic [CNT_W-1:0] fsw_smear(input logic [CNT_W-1:0] x);
    logic [CNT_W-1:0] m;
    m = x;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- sv/fsw_bitmap.sv -----
// Membership bitmap: rows of ROW_W bits, two registered read ports, one write port.
// Depends on fsw_pkg for the row width and the port control struct.
`timescale 1ns / 1ps
`default_nettype none

module fsw_bitmap import fsw_pkg::*; #(
  parameter int ROWS = 128,
  parameter int RAW  = 7
) (
  input  wire logic             clk,
  input  wire mem_ctl_t         ctl,
  input  wire logic [RAW-1:0]   rd_addr_a,
  input  wire logic [RAW-1:0]   rd_addr_b,
  input  wire logic [RAW-1:0]   wr_addr,
  input  wire logic [ROW_W-1:0] wr_data,
  output logic      [ROW_W-1:0] rd_data_a,
  output logic      [ROW_W-1:0] rd_data_b
);

  logic [ROW_W-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

// ----- sv/fsw_ctrl.sv -----
// Run control for the Floyd sampler: start handling, clearing pass, word draws
// and the output register. Depends on fsw_pkg and drives the fsw_bitmap ports.
`timescale 1ns / 1ps
`default_nettype none
`include "floyd_sample_without_replacement_defines.svh"

module fsw_ctrl import fsw_pkg::*; #(
  parameter int POP_MAX = POP_MAX_DEF,
  parameter int ROWS    = 128,
  parameter int RAW     = 7
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [CNT_W-1:0] pop_size,
  input  wire logic [CNT_W-1:0] sample_size,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic             s_mode,
  input  wire logic [31:0]      s_word,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic      [OUT_W-1:0] m_value,
  output logic      [OUT_W-1:0] m_ordinal,
  output logic                  m_last,
  output mem_ctl_t              mem_ctl,
  output logic      [RAW-1:0]   rd_addr_a,
  output logic      [RAW-1:0]   rd_addr_b,
  output logic      [RAW-1:0]   wr_addr,
  output logic      [ROW_W-1:0] wr_data,
  input  wire logic [ROW_W-1:0] rd_data_a,
  input  wire logic [ROW_W-1:0] rd_data_b
);

  localparam logic [CNT_W-1:0] POP_LIM =
    CNT_W'((POP_MAX > (1 << CNT_W) - 1) ? (1 << CNT_W) - 1 : POP_MAX);

  typedef enum logic [1:0] {S_IDLE, S_CLEAR, S_WR} state_t;

  state_t           state;
  logic             run_active;
  logic [CNT_W-1:0] run_pop;
  logic [CNT_W-1:0] cand;
  logic [CNT_W-1:0] taken;
  logic [CNT_W-1:0] r_q;
  logic [RAW-1:0]   clr_row;

  logic             accept;
  logic             live;
  logic             draw;
  logic             out_free;
  logic             commit;
  logic             hit;
  logic [CNT_W-1:0] bound;
  logic [CNT_W-1:0] r;
  logic [CNT_W-1:0] chosen;
  logic [CNT_W-1:0] p_eff;
  logic [CNT_W-1:0] m_eff;
  logic [ROW_W-1:0] row_set;

  always_comb begin
    s_tready = (state == S_IDLE);
    accept   = s_tvalid && s_tready;
    bound    = cand + 1'b1;
    r        = s_word[CNT_W-1:0] & fsw_smear(bound);
    live     = run_active && (cand < run_pop);
    draw     = accept && (s_mode == MODE_WORD) && live && (r < bound);
    out_free = !m_tvalid || m_tready;
    commit   = (state == S_WR) && out_free;

    p_eff = (pop_size > POP_LIM) ? POP_LIM : pop_size;
    m_eff = (sample_size > p_eff) ? p_eff : sample_size;

    // A drawn value already in the set is replaced by the candidate.
    hit     = rd_data_a[r_q[BIT_W-1:0]];
    chosen  = hit ? cand : r_q;
    row_set = (hit ? rd_data_b : rd_data_a) | (ROW_W'(1) << chosen[BIT_W-1:0]);

    mem_ctl.rd = draw;
    mem_ctl.wr = (state == S_CLEAR) || commit;
    rd_addr_a  = RAW'(r >> BIT_W);
    rd_addr_b  = RAW'(cand >> BIT_W);
    wr_addr    = (state == S_CLEAR) ? clr_row : RAW'(chosen >> BIT_W);
    wr_data    = (state == S_CLEAR) ? '0 : row_set;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      run_active <= 1'b0;
      run_pop    <= '0;
      cand       <= '0;
      taken      <= '0;
      clr_row    <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      // A beat taken by the receiver frees the output register unless a new
      // index is loaded into it in the same cycle.
      if (m_tready && !commit) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && s_mode == MODE_START) begin
            run_pop    <= p_eff;
            cand       <= p_eff - m_eff;
            taken      <= '0;
            run_active <= (m_eff != '0);
            clr_row    <= '0;
            state      <= S_CLEAR;
          end else if (accept && !live) begin
            run_active <= 1'b0;
          end else if (draw) begin
            state <= S_WR;
          end
        end
        S_CLEAR: begin
          clr_row <= clr_row + 1'b1;
          if (clr_row == RAW'(ROWS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_WR: begin
          if (commit) begin
            m_tvalid  <= 1'b1;
            m_value   <= chosen[OUT_W-1:0];
            m_ordinal <= taken[OUT_W-1:0];
            m_last    <= (bound == run_pop);
            taken     <= taken + 1'b1;
            cand      <= bound;
            if (bound >= run_pop) begin
              run_active <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Drawn word is held for the write-back cycle.
  always_ff @(posedge clk) begin
    if (draw) begin
      r_q <= r;
    end
  end

  `FSW_ASSERT_IMP(a_idle_no_write, state == S_IDLE, !mem_ctl.wr, "bitmap written while idle")
  `FSW_ASSERT_IMP(a_run_in_range, run_active, cand < run_pop, "active run past population")
  `FSW_ASSERT(a_commit_counts, commit |=> (taken == $past(taken) + 1'b1), "ordinal skipped")
  `FSW_ASSERT(a_out_from_wr, $rose(m_tvalid) |-> $past(state == S_WR), "result not from draw")
  `FSW_ASSERT(a_start_clears, (accept && s_mode == MODE_START) |=> (state == S_CLEAR), "no clear")

endmodule

`default_nettype wire

// ----- sv/floyd_sample_without_replacement.sv -----
// Top level of the Floyd sampler: configuration registers, run control and bitmap.
// Depends on fsw_pkg, fsw_ctrl and fsw_bitmap.
//
//   Channel   Direction  Beat contents
//   s_axis    in         tuser = mode, tdata = random_word
//   m_axis    out        tdata = sample_value, sample_ordinal; tlast = last
//   cfg       in         cfg_index selects pop_size (0) or sample_size (1)
//
// A random word that is rejected or arrives with no run active leaves the block idle.
// A word that draws an index first reads the two bitmap rows (drawn value and
// candidate) and then writes back the chosen row.
// A start beat runs a clearing pass over every bitmap row, one row per cycle.
// Reset clears only control state; the bitmap is cleared by each start beat. A held
// result on m_axis stalls only the write-back cycle of the next drawn index.
`timescale 1ns / 1ps
`default_nettype none

module floyd_sample_without_replacement import fsw_pkg::*; #(
  parameter int POP_MAX = POP_MAX_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // Input stream.
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [31:0]      s_axis_tdata,   // [31:0] random_word
  input  wire logic             s_axis_tuser,   // [0] mode
  // Output stream.
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic      [23:0]      m_axis_tdata,   // [11:0] sample_value, [23:12] sample_ordinal
  output logic                  m_axis_tlast,
  // Configuration write port.
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CNT_W-1:0] cfg_wdata
);

  // The bitmap is held in rows of ROW_W bits.
  localparam int ROWS = (POP_MAX + ROW_W - 1) / ROW_W;
  localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [CNT_W-1:0] pop_size;
  logic [CNT_W-1:0] sample_size;

  mem_ctl_t         mem_ctl;
  logic [RAW-1:0]   rd_addr_a;
  logic [RAW-1:0]   rd_addr_b;
  logic [RAW-1:0]   wr_addr;
  logic [ROW_W-1:0] wr_data;
  logic [ROW_W-1:0] rd_data_a;
  logic [ROW_W-1:0] rd_data_b;
  logic [OUT_W-1:0] value;
  logic [OUT_W-1:0] ordinal;

  // Registers take effect at the next start beat, when the run latches them.
  always_ff @(posedge clk) begin
    if (rst) begin
      pop_size    <= CNT_W'(4096);
      sample_size <= CNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POP_SIZE:    pop_size    <= cfg_wdata;
        REG_SAMPLE_SIZE: sample_size <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  fsw_ctrl #(
    .POP_MAX (POP_MAX),
    .ROWS    (ROWS),
    .RAW     (RAW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pop_size    (pop_size),
    .sample_size (sample_size),
    .s_tvalid    (s_axis_tvalid),
    .s_tready    (s_axis_tready),
    .s_mode      (s_axis_tuser),
    .s_word      (s_axis_tdata),
    .m_tvalid    (m_axis_tvalid),
    .m_tready    (m_axis_tready),
    .m_value     (value),
    .m_ordinal   (ordinal),
    .m_last      (m_axis_tlast),
    .mem_ctl     (mem_ctl),
    .rd_addr_a   (rd_addr_a),
    .rd_addr_b   (rd_addr_b),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_data_a   (rd_data_a),
    .rd_data_b   (rd_data_b)
  );

  fsw_bitmap #(
    .ROWS (ROWS),
    .RAW  (RAW)
  ) u_bitmap (
    .clk       (clk),
    .ctl       (mem_ctl),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  assign m_axis_tdata = {ordinal, value};

endmodule

`default_nettype wire

// ----- bench/floyd_sample_without_replacement_tb.sv -----
// Self-checking testbench for the Floyd sampler: a directed script, then randomized runs.
// Depends on fsw_pkg and floyd_sample_without_replacement; reads no files.
`timescale 1ns / 1ps

module floyd_sample_without_replacement_tb;
  import fsw_pkg::*;

  // Cycles that cover the clearing pass of a start beat plus margin. The block
  // is left alone this long before any register write and at the end of the run.
  localparam int SETTLE_CYCLES = 200;
  // Length of the single long output stall that backs the block up.
  localparam int HOLD_CYCLES   = 400;
  // Useful beats (starts and words seen by a live run) in the random part.
  localparam int RANDOM_BEATS  = 1600;
  localparam logic [CNT_W-1:0] POP_CAP = CNT_W'(POP_MAX_DEF);

  // One drawn index as it leaves the block.
  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic [OUT_W-1:0] ordinal;
    logic             last;
  } pick_t;

  // How a script row is checked: by the predictor, as producing nothing, or
  // against a result typed into the row.
  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_PICK} chk_e;
  typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_e;
  // Receiver behavior, changed from phase to phase.
  typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_PERIODIC, RX_SPARSE} rx_style_e;

  typedef struct packed {
    row_kind_e        kind;
    logic             idx;    // register index, ROW_CFG only
    logic [CNT_W-1:0] val;    // register value, ROW_CFG only
    logic             md;
    logic [31:0]      word;
    chk_e             chk;
    pick_t            pick;
  } row_t;

  localparam pick_t NO_PICK = '0;

  // Directed script. Typed results follow directly from the register values:
  // masks are 2*p-1 with p the largest power of two not above candidate+1.
  localparam row_t DIRECTED_ROWS [0:28] = '{
    // A word before any start beat is dropped.
    '{ROW_BEAT, REG_POP_SIZE, 13'd0, MODE_WORD, 32'hFFFF_FFFF, EXP_NONE, NO_PICK},
    // Reset settings: population 4096, one index, so the candidate is 4095.
    '{ROW_BEAT, REG_POP_SIZE, 13'd0, MODE_START, 32'h0000_0000, EXP_NONE, NO_PICK},
    '{ROW_BEAT, REG_POP_SIZE, 13'd0, MODE_WORD, 32'h0000_1FFF, EXP_NONE, NO_PICK},
    '{ROW_BEAT, REG_POP_SIZE, 13'd0, MODE_WORD, 32'hFFFF_EFFF, EXP_PICK,
      '{12'd4095, 12'd0, 1'b1}},
    // The run is over, so this word is dropped.
    '{ROW_BEAT, REG_POP_SIZE, 13'd0, MODE_WORD, 32'h0000_0000, EXP_NONE, NO_PICK},
    // Smallest population: a one-bit mask, first word rejected.
    '{ROW_CFG, REG_POP_SIZE, 13'd1, MODE_WORD, 32'h0, EXP_NONE, NO_PICK},
    '{ROW_BEAT, REG_POP_SIZE, 13'd0, MODE_START, 32'hFFFF_FFFF, EXP_NONE, NO_PICK},
    '{ROW_BEAT, REG_POP_SIZE, 13'd0, MODE_WORD, 32'h0000_0001, EXP_NONE, NO_PICK},
    '{ROW_BEAT, REG_POP_SIZE, 13'd0, MODE_WORD, 32'hFFFF_FFFE, EXP_PICK,
      '{12'd0, 12'd0, 1'b1}},
    // Empty sample: the start leaves the run inactive.
    '{ROW_CFG, REG_SAMPLE_SIZE, 13'd0, MODE_WORD, 32'h0, EXP_NONE, NO_PICK},
    '{ROW_BEAT, REG_POP_SIZE, 13'd0, MODE_START, 32'h0000_0000, EXP_NONE, NO_PICK},
    '{ROW_BEAT, REG_POP_SIZE, 13'd0, MODE_WORD, 32'h0000_0000, EXP_NONE, NO_PICK},
    // Oversized population and oversized sample: both clamp to the capacity.
    '{ROW_CFG, REG_POP_SIZE, 13'd8191, MODE_WORD, 32'h0, EXP_NONE, NO_PICK},
    '{ROW_CFG, REG_SAMPLE_SIZE, 13'd8191, MODE_WORD, 32'h0, EXP_NONE, NO_PICK},
    '{ROW_BEAT, REG_POP_SIZE, 13'd0, MODE_START, 32'h0000_0000, EXP_NONE, NO_PICK},
    '{ROW_BEAT, REG_POP_SIZE, 13'd0, MODE_WORD, 32'h0000_0000, EXP_PICK,
      '{12'd0, 12'd0, 1'b0}},
    '{ROW_BEAT, REG_POP_SIZE, 13'd0, MODE_WORD, 32'h0000_0003, EXP_NONE, NO_PICK},
    // Value 0 is taken already, so the candidate itself is drawn.
    '{ROW_BEAT, REG_POP_SIZE, 13'd0, MODE_WORD, 32'h0000_0000, EXP_PICK,
      '{12'd1, 12'd1, 1'b0}},
    '{ROW_BEAT, REG_POP_SIZE, 13'd0, MODE_WORD, 32'h0000_0002, EXP_PICK,
      '{12'd2, 12'd2, 1'b0}},
    // A register write mid-run has no effect until the next start.
    '{ROW_CFG, REG_POP_SIZE, 13'd3, MODE_WORD, 32'h0, EXP_NONE, NO_PICK},
    '{ROW_BEAT, REG_POP_SIZE, 13'd0, MODE_WORD, 32'h0000_0004, EXP_NONE, NO_PICK},
    '{ROW_BEAT, REG_POP_SIZE, 13'd0, MODE_WORD, 32'h5A5A_5A5B, EXP_MODEL, NO_PICK},
    // Restart in the middle of a run with population 3, sample 2.
    '{ROW_CFG, REG_SAMPLE_SIZE, 13'd2, MODE_WORD, 32'h0, EXP_NONE, NO_PICK},
    '{ROW_BEAT, REG_POP_SIZE, 13'd0, MODE_START, 32'h0000_0000, EXP_NONE, NO_PICK},
    '{ROW_BEAT, REG_POP_SIZE, 13'd0, MODE_WORD, 32'h8000_0001, EXP_PICK,
      '{12'd1, 12'd0, 1'b0}},
    '{ROW_CFG, REG_POP_SIZE, 13'd0, MODE_WORD, 32'h0, EXP_NONE, NO_PICK},
    // Collision on the last draw: the candidate is taken and flagged last.
    '{ROW_BEAT, REG_POP_SIZE, 13'd0, MODE_WORD, 32'hFFFF_FFFD, EXP_PICK,
      '{12'd2, 12'd1, 1'b1}},
    // Empty population: the start leaves the run inactive.
    '{ROW_BEAT, REG_POP_SIZE, 13'd0, MODE_START, 32'h0000_0000, EXP_NONE, NO_PICK},
    '{ROW_BEAT, REG_POP_SIZE, 13'd0, MODE_WORD, 32'hFFFF_FFFF, EXP_NONE, NO_PICK}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [31:0]      s_axis_tdata = '0;   // [31:0] random_word
  logic             s_axis_tuser = MODE_WORD;   // [0] mode
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [23:0]      m_axis_tdata;   // [11:0] sample_value, [23:12] sample_ordinal
  logic             m_axis_tlast;
  logic             cfg_we = 1'b0;
  logic             cfg_index = REG_POP_SIZE;
  logic [CNT_W-1:0] cfg_wdata = '0;

  floyd_sample_without_replacement dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Predictor state: register copies, the membership map and the run counters.
  logic [CNT_W-1:0]       want_pop = POP_CAP;
  logic [CNT_W-1:0]       want_samp = 13'd1;
  logic [POP_MAX_DEF-1:0] map_bits = '0;
  logic [CNT_W-1:0]       cand_idx = '0;
  logic [CNT_W-1:0]       drawn_cnt = '0;
  logic [CNT_W-1:0]       run_pop_q = '0;
  bit                     run_live = 1'b0;

  // Indices still owed by the block, oldest first.
  pick_t picks_due[$];

  int errors = 0;
  int beats_sent = 0;
  int starts_sent = 0;
  int useful_beats = 0;
  int picks_seen = 0;
  int settings_used = 0;

  // Sender and receiver knobs, set by the main sequence between phases.
  int        burst_left = 0;
  bit        steady = 1'b0;
  rx_style_e rx_style = RX_OPEN;
  bit        hold_req = 1'b0;

  // Works out what one accepted beat does to the sampler and whether it draws
  // an index. A start latches the clamped population and sample size, clears
  // the map and sets the candidate to P-M. A word is masked to the power-of-two
  // span above candidate+1 and rejected if it lands on or past that bound.
  function automatic bit forecast_pick(input logic md, input logic [31:0] w,
                                       output pick_t pick);
    logic [CNT_W-1:0] p, m, bound, mask, r, chosen;
    logic [CNT_W:0]   span;
    int               lead;
    pick = '0;
    if (md == MODE_START) begin
      p = (want_pop > POP_CAP) ? POP_CAP : want_pop;
      m = (want_samp > p) ? p : want_samp;
      map_bits = '0;
      run_pop_q = p;
      cand_idx = p - m;
      drawn_cnt = '0;
      run_live = (m != '0);
      return 1'b0;
    end
    if (!run_live || cand_idx >= run_pop_q) begin
      run_live = 1'b0;
      return 1'b0;
    end
    bound = cand_idx + 1'b1;
    lead = 0;
    for (int b = 0; b < CNT_W; b++) begin
      if (bound[b]) lead = b;
    end
    span = (CNT_W + 1)'(1) << (lead + 1);
    mask = CNT_W'(span - 1'b1);
    r = w[CNT_W-1:0] & mask;
    if (r >= bound) return 1'b0;
    chosen = map_bits[r[OUT_W-1:0]] ? cand_idx : r;
    map_bits[chosen[OUT_W-1:0]] = 1'b1;
    pick.value = chosen[OUT_W-1:0];
    pick.ordinal = drawn_cnt[OUT_W-1:0];
    pick.last = (bound == run_pop_q);
    drawn_cnt = drawn_cnt + 1'b1;
    cand_idx = bound;
    if (bound >= run_pop_q) run_live = 1'b0;
    return 1'b1;
  endfunction

  // Offers one beat, keeping the sender's burst pattern: after each burst a
  // random gap with tvalid low, unless the phase runs steady. Returns at the
  // rising edge that accepted the beat, after booking what it should produce.
  task automatic offer(input logic md, input logic [31:0] w, input chk_e chk,
                       input pick_t typed);
    int    gap;
    bit    hit;
    pick_t got;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(1, 7);
      repeat (gap) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= md;
    s_axis_tdata <= w;
    do @(posedge clk); while (!s_axis_tready);
    beats_sent++;
    if (md == MODE_START) starts_sent++;
    if (md == MODE_START || run_live) useful_beats++;
    hit = forecast_pick(md, w, got);
    if (chk == EXP_PICK) picks_due.push_back(typed);
    else if (chk == EXP_MODEL && hit) picks_due.push_back(got);
  endtask

  // Drops tvalid and waits until every owed index has come out and any
  // clearing pass is surely over, so that the block is idle.
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CNT_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_POP_SIZE) want_pop = val;
    else want_samp = val;
  endtask

  // Receiver: tready follows the phase's style, except during the long hold,
  // which is counted here once the main sequence asks for it.
  initial begin : receiver
    int hold_left;
    int tick;
    hold_left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_style)
          RX_OPEN:     m_axis_tready <= 1'b1;
          RX_CHOPPY:   m_axis_tready <= ($urandom_range(0, 3) != 0);
          RX_PERIODIC: m_axis_tready <= ((tick % 7) >= 3);
          default:     m_axis_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Every output beat is matched against the oldest owed index.
  always @(posedge clk) begin : check_picks
    pick_t due;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      picks_seen++;
      if (picks_due.size() == 0) begin
        $display("%0t: unexpected beat: expected none, got value %0d ordinal %0d last %0b",
                 $time, m_axis_tdata[11:0], m_axis_tdata[23:12], m_axis_tlast);
        errors++;
      end else begin
        due = picks_due.pop_front();
        if (m_axis_tdata[11:0] !== due.value) begin
          $display("%0t: sample_value: expected %0d, got %0d",
                   $time, due.value, m_axis_tdata[11:0]);
          errors++;
        end
        if (m_axis_tdata[23:12] !== due.ordinal) begin
          $display("%0t: sample_ordinal: expected %0d, got %0d",
                   $time, due.ordinal, m_axis_tdata[23:12]);
          errors++;
        end
        if (m_axis_tlast !== due.last) begin
          $display("%0t: last: expected %0b, got %0b", $time, due.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #12_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : main
    int          phase_no;
    int          runs;
    int          abort_at;
    int          n;
    int          sel;
    int          goal;
    int unsigned pop;
    int unsigned samp;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed script, with the receiver always ready.
    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].kind == ROW_CFG) begin
        settle();
        write_reg(DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].val);
        settings_used++;
      end else begin
        offer(DIRECTED_ROWS[i].md, DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].chk,
              DIRECTED_ROWS[i].pick);
      end
    end

    // Random phases: a fresh register setting, then one to three runs of a start
    // followed by words until the sample is complete. Some runs are cut short by
    // the next start, and up to two stray words follow each run.
    goal = useful_beats + RANDOM_BEATS;
    phase_no = 0;
    while (useful_beats < goal) begin
      phase_no++;
      sel = $urandom_range(0, 19);
      if (phase_no == 2) begin
        // Full draw of a mid-sized population, used for the long output stall.
        pop = 64;
        samp = 64;
      end else if (sel == 0) begin
        pop = $urandom_range(4097, 8191);
        samp = $urandom_range(1, 6);
      end else if (sel == 1) begin
        pop = POP_MAX_DEF;
        samp = $urandom_range(1, 12);
      end else if (sel == 2) begin
        pop = $urandom_range(1, 16);
        samp = $urandom_range(pop + 1, 8191);
      end else if (sel == 3) begin
        if ($urandom_range(0, 1) == 0) begin
          pop = 0;
          samp = $urandom_range(0, 8191);
        end else begin
          pop = $urandom_range(1, 8191);
          samp = 0;
        end
      end else if (sel <= 5) begin
        pop = $urandom_range(17, 300);
        samp = $urandom_range(1, 40);
      end else begin
        pop = $urandom_range(1, 48);
        samp = $urandom_range(1, pop);
      end
      settle();
      write_reg(REG_POP_SIZE, CNT_W'(pop));
      write_reg(REG_SAMPLE_SIZE, CNT_W'(samp));
      settings_used++;
      rx_style = rx_style_e'($urandom_range(0, 3));
      steady = ($urandom_range(0, 3) == 0);

      runs = $urandom_range(1, 3);
      for (int k = 0; k < runs; k++) begin
        abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 0;
        offer(MODE_START, $urandom, EXP_MODEL, NO_PICK);
        // Hold the output off while the sender keeps going, so the block backs up.
        if (phase_no == 2 && k == 0) hold_req = 1'b1;
        n = 0;
        while (run_live && !(abort_at != 0 && n == abort_at)) begin
          offer(MODE_WORD, $urandom, EXP_MODEL, NO_PICK);
          n++;
        end
        repeat ($urandom_range(0, 2)) offer(MODE_WORD, $urandom, EXP_MODEL, NO_PICK);
      end
    end

    settle();
    $display("summary: %0d beats accepted (%0d starts), %0d indices checked",
             beats_sent, starts_sent, picks_seen);
    $display("summary: %0d register settings incl. empty, clamped and oversized; %0d phases",
             settings_used, phase_no);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
